/* rtl/cfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants for the checksummed frame reassembler.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned SlotCount = 8;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned IdW       = 11;
  localparam int unsigned LenW      = 4;
  localparam int unsigned PayloadW  = SlotCount * ByteW;

  localparam logic [ByteW-1:0] StartByte = 8'hFF;
  localparam logic [ByteW-1:0] FillByte  = 8'hFF;
  localparam logic [ByteW-1:0] IdHiMask  = 8'hE0;
  localparam logic [ByteW-1:0] LenMask   = 8'h0F;
  localparam logic [ByteW-1:0] ChanMask  = 8'h10;
  localparam logic [IdW-1:0]   IdReset   = 11'h0FF;
  localparam logic [LenW-1:0]  LenReset  = 4'hF;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_IDLO = 3'd1,
    PH_HDR  = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [IdW-1:0]      frame_id;
    logic                frame_channel;
    logic [LenW-1:0]     data_length;
    logic [PayloadW-1:0] payload;
  } frame_t;

endpackage

/* rtl/cfr_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_parser
// Frame parser: tracks the frame phase, collects data bytes, keeps the
// running checksum and flags a finished frame on a matching checksum word.
// ----------------------------------------------------------------------------
module cfr_parser import cfr_pkg::*; #(
  parameter int unsigned MAX_DATA = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             word_fire_i,
  input  logic [ByteW-1:0] word_i,
  output logic             frame_valid_o,
  output frame_t           frame_o
);

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_DATA);

  phase_e           phase_q, phase_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             chan_q, chan_d;
  logic [LenW-1:0]  idx_q, idx_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] store_q [SlotCount];
  logic [ByteW-1:0] store_d [SlotCount];

  logic [LenW-1:0]  hdr_len;
  logic [LenW-1:0]  idx_inc;

  assign hdr_len = LenW'(word_i & LenMask);
  assign idx_inc = idx_q + LenW'(1);

  // next state
  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    len_d   = len_q;
    chan_d  = chan_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    store_d = store_q;
    if (word_fire_i) begin
      case (phase_q)
        PH_IDLO: begin
          id_d    = IdW'(word_i);
          sum_d   = word_i;
          phase_d = PH_HDR;
        end
        PH_HDR: begin
          id_d   = {word_i[7:5], id_q[7:0]};
          len_d  = hdr_len;
          chan_d = |(word_i & ChanMask);
          idx_d  = '0;
          sum_d  = sum_q + word_i;
          if (hdr_len > MaxLen) begin
            phase_d = PH_HUNT;
          end else if (hdr_len != '0) begin
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_SUM;
          end
        end
        PH_DATA: begin
          store_d[idx_q[2:0]] = word_i;
          idx_d = idx_inc;
          sum_d = sum_q + word_i;
          if (idx_inc >= len_q) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_d = PH_HUNT;
        end
        default: begin
          id_d   = IdReset;
          len_d  = LenReset;
          chan_d = 1'b0;
          sum_d  = '0;
          for (int i = 0; i < SlotCount; i++) begin
            store_d[i] = FillByte;
          end
          phase_d = (word_i == StartByte) ? PH_IDLO : PH_HUNT;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    frame_valid_o         = word_fire_i && (phase_q == PH_SUM) && (word_i == sum_q);
    frame_o.frame_id      = id_q;
    frame_o.frame_channel = chan_q;
    frame_o.data_length   = len_q;
    for (int i = 0; i < SlotCount; i++) begin
      frame_o.payload[i*ByteW +: ByteW] = store_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      id_q    <= IdReset;
      len_q   <= LenReset;
      chan_q  <= 1'b0;
      idx_q   <= '0;
      sum_q   <= '0;
      for (int i = 0; i < SlotCount; i++) begin
        store_q[i] <= FillByte;
      end
    end else begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      chan_q  <= chan_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      store_q <= store_d;
    end
  end

endmodule

/* rtl/cfr_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_out_buf
// Two-entry result buffer: an output register backed by a skid register so
// the parser keeps taking words while a frame waits on a stalled receiver.
// ----------------------------------------------------------------------------
module cfr_out_buf import cfr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t frame_i,
  output logic   full_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output frame_t frame_o
);

  logic   out_valid_q, out_valid_d;
  logic   skid_valid_q, skid_valid_d;
  frame_t out_q, out_d;
  frame_t skid_q, skid_d;
  logic   out_fire;

  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_d       = frame_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = frame_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign frame_o     = out_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("frame pushed into full buffer");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i && push_i))
    else $error("skid filled without a stalled output");

  a_skid_drains_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_fire) |=> (out_valid_q && !skid_valid_q && out_q == $past(skid_q)))
    else $error("skid entry not moved to output");

endmodule

/* rtl/checksummed_frame_reassembler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_reassembler_top
// Rebuilds checksummed frames from a stream of received serial bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per word on rx_byte_i, taken at a clock
//   edge with in_valid_i high and in_stall_o low.
//   Output channel: one frame per word (frame_id_o, frame_channel_o,
//   data_length_o, payload_o), taken with out_valid_o high and out_stall_i
//   low. Data byte i sits in payload_o[8i+7:8i]; unused bytes read 0xFF.
//   Frames with a length above MAX_DATA or a bad checksum are dropped.
//   Throughput: one byte per cycle while in_stall_o is low.
//   A frame is registered in the output buffer as its checksum byte is taken.
//   Reset: the parser hunts for a start byte, the output buffer is empty.
//   Receiver stall: the pending frame holds; a second frame lands in a skid
//   register, and in_stall_o rises only while that register is occupied.
// ----------------------------------------------------------------------------
module checksummed_frame_reassembler_top import cfr_pkg::*; #(
  parameter int unsigned MAX_DATA = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IdW-1:0]      frame_id_o,
  output logic                frame_channel_o,
  output logic [LenW-1:0]     data_length_o,
  output logic [PayloadW-1:0] payload_o
);

  logic   word_fire;
  logic   frame_valid;
  frame_t frame_new;
  frame_t frame_out;
  logic   buf_full;

  assign in_stall_o = buf_full;
  assign word_fire  = in_valid_i && !buf_full;

  cfr_parser #(
    .MAX_DATA(MAX_DATA)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_fire_i  (word_fire),
    .word_i       (rx_byte_i),
    .frame_valid_o(frame_valid),
    .frame_o      (frame_new)
  );

  cfr_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (frame_valid),
    .frame_i    (frame_new),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .frame_o    (frame_out)
  );

  assign frame_id_o      = frame_out.frame_id;
  assign frame_channel_o = frame_out.frame_channel;
  assign data_length_o   = frame_out.data_length;
  assign payload_o       = frame_out.payload;

endmodule
